/* hdl/lopm_pkg.sv */
// Shared types, constants and arithmetic helpers for the layer optical property mixer.
// No dependencies; the other files that use it refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lopm_pkg;

   localparam int MAX_CONSTITUENTS_DEF = 16;
   localparam int MOMENT_TERMS_DEF     = 5;
   localparam int INPUT_MOMENTS        = 5;
   localparam int TERM_W               = 3;  // holds 0..INPUT_MOMENTS

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_ZERO_DEPTH  = 2'd1;
   localparam logic [1:0] ST_ZERO_SCATTER = 2'd2;
   localparam logic [1:0] ST_ZERO_MOMENT = 2'd3;

   // division jobs; normalized moment k (k >= 2) is job k
   localparam logic [TERM_W-1:0] JOB_ALBEDO = 3'd0;
   localparam logic [TERM_W-1:0] JOB_ASYM   = 3'd1;
   localparam logic [TERM_W-1:0] JOB_MOM1   = 3'd2;

   localparam logic [15:0] ALBEDO_ONE = 16'd32768;
   localparam logic [15:0] POS_SAT    = 16'h7FFF;
   localparam logic [15:0] NEG_SAT    = 16'h8000;

   typedef struct packed {
      logic              take;
      logic              mul_sc;
      logic              mul_term;
      logic [TERM_W-1:0] term;
      logic              clear_res;
      logic              div_phase;
      logic              div_start;
      logic [TERM_W-1:0] job;
      logic              store;
      logic              publish;
   } lopm_cmd_type;

   typedef struct packed {
      logic item_in;
      logic phase;
      logic close;
      logic depth_zero;
      logic scat_zero;
      logic mom0_zero;
      logic div_done;
      logic out_free;
   } lopm_stat_type;

   function automatic logic [39:0] sat_add_depth(input logic [39:0] a, input logic [31:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {9'b0, b};
      return s[40] ? {40{1'b1}} : s[39:0];
   endfunction

   function automatic logic [51:0] sat_add_scat(input logic [51:0] a, input logic [47:0] b);
      logic [52:0] s;
      s = {1'b0, a} + {5'b0, b};
      return s[52] ? {52{1'b1}} : s[51:0];
   endfunction

   function automatic logic [63:0] sat_add_s64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

endpackage

`default_nettype wire

/* hdl/lopm_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface lopm_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        tau_part;
   logic [15:0]        albedo_part;
   logic signed [15:0] asym_part;
   logic               phase_listed;
   logic signed [15:0] moment_one;
   logic signed [15:0] moment_two;
   logic signed [15:0] moment_three;
   logic signed [15:0] moment_four;
   logic signed [15:0] moment_five;
   logic               last_constituent;

   modport source (output valid, tau_part, albedo_part, asym_part, phase_listed, moment_one,
                   moment_two, moment_three, moment_four, moment_five, last_constituent,
                   input ready);
   modport sink (input valid, tau_part, albedo_part, asym_part, phase_listed, moment_one,
                 moment_two, moment_three, moment_four, moment_five, last_constituent,
                 output ready);
endinterface

interface lopm_rsp_if;
   logic               valid;
   logic               ready;
   logic [39:0]        tau_total;
   logic [15:0]        layer_albedo;
   logic signed [15:0] layer_asymmetry;
   logic signed [15:0] norm_moment_two;
   logic signed [15:0] norm_moment_three;
   logic signed [15:0] norm_moment_four;
   logic signed [15:0] norm_moment_five;
   logic [1:0]         status;

   modport source (output valid, tau_total, layer_albedo, layer_asymmetry, norm_moment_two,
                   norm_moment_three, norm_moment_four, norm_moment_five, status,
                   input ready);
   modport sink (input valid, tau_total, layer_albedo, layer_asymmetry, norm_moment_two,
                 norm_moment_three, norm_moment_four, norm_moment_five, status,
                 output ready);
endinterface

`default_nettype wire

/* hdl/layer_optical_property_mixer.sv */
// Per request: one multiply for the scattering depth, then one per weighted term, the
// asymmetry plus min(MOMENT_TERMS, 5) moments when the phase flag is set, on the single
// shared multiplier with one accumulate per weighted term. Layer close runs albedo,
// asymmetry and up to four moment ratios on one 17-step restoring divider.
// The next request is taken while a finished response waits in the output register.
// Synchronous active-high reset clears the controller, counter and accumulators.
`timescale 1ns / 1ps
`default_nettype none

module layer_optical_property_mixer #(
   parameter int MAX_CONSTITUENTS = lopm_pkg::MAX_CONSTITUENTS_DEF,
   parameter int MOMENT_TERMS     = lopm_pkg::MOMENT_TERMS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   lopm_req_if.sink   req_bus,
   lopm_rsp_if.source rsp_bus
);

   lopm_pkg::lopm_cmd_type  cmd;
   lopm_pkg::lopm_stat_type stat;

   lopm_ctrl #(
      .MOMENT_TERMS (MOMENT_TERMS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   lopm_datapath #(
      .MAX_CONSTITUENTS (MAX_CONSTITUENTS),
      .MOMENT_TERMS     (MOMENT_TERMS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire

/* hdl/lopm_div.sv */
// Restoring divider: 16 quotient bits of (num << frac) / den plus overflow flag.
// One bit per cycle. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module lopm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   input  wire logic        frac_en,
   output logic             done,
   output logic [15:0]      quot,
   output logic             ovf
);

   localparam int DW = 80;
   localparam logic [4:0] STEPS = 5'd17;

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsh_ff, dsh_in;
   logic [15:0]   q_ff, q_in;
   logic          ovf_ff, ovf_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = frac_en ? {5'b0, num, 11'b0} : {16'b0, num};
         dsh_in  = {den, 16'b0};
         cnt_in  = STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // first step only checks quotient range against den << 16
         if (cnt_ff == STEPS) begin
            ovf_in = ge;
         end else begin
            q_in = {q_ff[14:0], ge};
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

/* hdl/lopm_datapath.sv */
// Datapath: item register, shared multiplier, saturating accumulators, divider,
// result staging and output register. Depends on lopm_pkg, lopm_if, lopm_div.
`timescale 1ns / 1ps
`default_nettype none

module lopm_datapath #(
   parameter int MAX_CONSTITUENTS = lopm_pkg::MAX_CONSTITUENTS_DEF,
   parameter int MOMENT_TERMS     = lopm_pkg::MOMENT_TERMS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   lopm_req_if.sink             req,
   lopm_rsp_if.source           rsp,
   input  lopm_pkg::lopm_cmd_type  cmd,
   output lopm_pkg::lopm_stat_type stat
);

   localparam int NUM_ACC = (MOMENT_TERMS < lopm_pkg::INPUT_MOMENTS) ?
                            MOMENT_TERMS : lopm_pkg::INPUT_MOMENTS;
   localparam int IDX_W = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;
   localparam int CNT_W = $clog2(MAX_CONSTITUENTS + 1);
   localparam int TW    = lopm_pkg::TERM_W;

   // item
   logic [31:0]        tau_ff;
   logic [15:0]        alb_ff;
   logic signed [15:0] asym_ff;
   logic               phase_ff;
   logic signed [15:0] mom_ff [NUM_ACC];
   logic               close_ff;
   logic [CNT_W-1:0]   count_ff;
   logic signed [15:0] mom_in [lopm_pkg::INPUT_MOMENTS];
   logic               load;

   // accumulators
   logic [39:0] depth_ff;
   logic [51:0] scat_ff;
   logic [63:0] asum_ff;
   logic [63:0] msum_ff [NUM_ACC];
   logic [47:0] sc_ff;
   logic [63:0] prod_ff;
   logic          acc_en_ff;
   logic [TW-1:0] acc_term_ff;

   // multiplier
   logic signed [16:0] mul_a;
   logic signed [48:0] mul_b;
   logic signed [65:0] prod;
   logic [IDX_W-1:0]   mom_idx;

   // division
   logic [IDX_W-1:0] rd_idx;
   logic [63:0]      msum_rd;
   logic [63:0]      div_num, div_den;
   logic             div_frac, div_neg, neg_ff;
   logic             div_done, div_ovf;
   logic [15:0]      div_q;
   logic             sat;
   logic [15:0]      sval;

   // staging and output
   logic [15:0] res_alb_ff, res_asym_ff;
   logic [15:0] res_mom_ff [4];
   logic        rsp_valid_ff;
   logic [39:0] o_tau_ff;
   logic [15:0] o_alb_ff, o_asym_ff;
   logic [15:0] o_mom_ff [4];
   logic [1:0]  o_st_ff, st_code;

   assign load = cmd.take && req.valid;
   assign req.ready = cmd.take;

   assign mom_in[0] = req.moment_one;
   assign mom_in[1] = req.moment_two;
   assign mom_in[2] = req.moment_three;
   assign mom_in[3] = req.moment_four;
   assign mom_in[4] = req.moment_five;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         if (req.last_constituent || count_ff == CNT_W'(MAX_CONSTITUENTS - 1)) begin
            count_ff <= '0;
         end else begin
            count_ff <= count_ff + 1'b1;
         end
      end
      if (load) begin
         tau_ff   <= req.tau_part;
         alb_ff   <= (req.albedo_part > lopm_pkg::ALBEDO_ONE) ?
                     lopm_pkg::ALBEDO_ONE : req.albedo_part;
         asym_ff  <= req.asym_part;
         phase_ff <= req.phase_listed;
         close_ff <= req.last_constituent || count_ff == CNT_W'(MAX_CONSTITUENTS - 1);
         for (int i = 0; i < NUM_ACC; i++) begin
            mom_ff[i] <= mom_in[i];
         end
      end
   end

   // shared multiplier: albedo x depth, then weights x scattering depth
   assign mom_idx = IDX_W'(cmd.term - 3'd1);
   always_comb begin
      if (cmd.mul_sc) begin
         mul_a = $signed({1'b0, alb_ff});
         mul_b = $signed({17'b0, tau_ff});
      end else begin
         if (cmd.term == '0) begin
            mul_a = {asym_ff[15], asym_ff};
         end else begin
            mul_a = {mom_ff[mom_idx][15], mom_ff[mom_idx]};
         end
         mul_b = $signed({1'b0, sc_ff});
      end
   end
   assign prod = mul_a * mul_b;

   // one read address into the moment sums, shared by accumulate and divide phases
   assign rd_idx  = cmd.div_phase ? IDX_W'(cmd.job - 3'd1) : IDX_W'(acc_term_ff - 3'd1);
   assign msum_rd = msum_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
         depth_ff  <= '0;
         scat_ff   <= '0;
         asum_ff   <= '0;
         for (int i = 0; i < NUM_ACC; i++) begin
            msum_ff[i] <= '0;
         end
      end else if (cmd.publish) begin
         acc_en_ff <= 1'b0;
         depth_ff  <= '0;
         scat_ff   <= '0;
         asum_ff   <= '0;
         for (int i = 0; i < NUM_ACC; i++) begin
            msum_ff[i] <= '0;
         end
      end else begin
         acc_en_ff <= cmd.mul_term;
         if (cmd.mul_sc) begin
            depth_ff <= lopm_pkg::sat_add_depth(depth_ff, tau_ff);
         end
         if (cmd.mul_term && cmd.term == '0) begin
            scat_ff <= lopm_pkg::sat_add_scat(scat_ff, sc_ff);
         end
         if (acc_en_ff) begin
            if (acc_term_ff == '0) begin
               asum_ff <= lopm_pkg::sat_add_s64(asum_ff, prod_ff);
            end else begin
               msum_ff[rd_idx] <= lopm_pkg::sat_add_s64(msum_rd, prod_ff);
            end
         end
      end
      if (cmd.mul_sc) begin
         sc_ff <= prod[47:0];
      end
      if (cmd.mul_term) begin
         prod_ff     <= prod[63:0];
         acc_term_ff <= cmd.term;
      end
   end

   // divider operands by job
   always_comb begin
      unique case (cmd.job)
         lopm_pkg::JOB_ALBEDO: begin
            div_num  = {12'b0, scat_ff};
            div_den  = {24'b0, depth_ff};
            div_frac = 1'b0;
            div_neg  = 1'b0;
         end
         lopm_pkg::JOB_ASYM: begin
            div_num  = lopm_pkg::mag64(asum_ff);
            div_den  = {12'b0, scat_ff};
            div_frac = 1'b0;
            div_neg  = asum_ff[63];
         end
         default: begin
            div_num  = lopm_pkg::mag64(msum_rd);
            div_den  = lopm_pkg::mag64(msum_ff[0]);
            div_frac = 1'b1;
            div_neg  = msum_rd[63] ^ msum_ff[0][63];
         end
      endcase
   end

   lopm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num     (div_num),
      .den     (div_den),
      .frac_en (div_frac),
      .done    (div_done),
      .quot    (div_q),
      .ovf     (div_ovf)
   );

   assign sat  = div_ovf || div_q[15];
   assign sval = neg_ff ? (sat ? lopm_pkg::NEG_SAT : 16'(~div_q + 16'd1)) :
                          (sat ? lopm_pkg::POS_SAT : div_q);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= div_neg;
      end
      if (cmd.clear_res) begin
         res_alb_ff  <= '0;
         res_asym_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            res_mom_ff[i] <= '0;
         end
      end else if (cmd.store) begin
         if (cmd.job == lopm_pkg::JOB_ALBEDO) begin
            res_alb_ff <= (div_ovf || div_q > lopm_pkg::ALBEDO_ONE) ?
                          lopm_pkg::ALBEDO_ONE : div_q;
         end else if (cmd.job == lopm_pkg::JOB_ASYM) begin
            res_asym_ff <= sval;
         end else begin
            for (int i = 0; i < 4; i++) begin
               if (cmd.job == lopm_pkg::JOB_MOM1 + TW'(i)) begin
                  res_mom_ff[i] <= sval;
               end
            end
         end
      end
   end

   always_comb begin
      priority if (depth_ff == '0) begin
         st_code = lopm_pkg::ST_ZERO_DEPTH;
      end else if (scat_ff == '0) begin
         st_code = lopm_pkg::ST_ZERO_SCATTER;
      end else if (msum_ff[0] == '0) begin
         st_code = lopm_pkg::ST_ZERO_MOMENT;
      end else begin
         st_code = lopm_pkg::ST_OK;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.publish) begin
         o_tau_ff  <= depth_ff;
         o_alb_ff  <= res_alb_ff;
         o_asym_ff <= res_asym_ff;
         o_mom_ff  <= res_mom_ff;
         o_st_ff   <= st_code;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.tau_total         = o_tau_ff;
   assign rsp.layer_albedo      = o_alb_ff;
   assign rsp.layer_asymmetry   = o_asym_ff;
   assign rsp.norm_moment_two   = o_mom_ff[0];
   assign rsp.norm_moment_three = o_mom_ff[1];
   assign rsp.norm_moment_four  = o_mom_ff[2];
   assign rsp.norm_moment_five  = o_mom_ff[3];
   assign rsp.status            = o_st_ff;

   assign stat.item_in    = req.valid;
   assign stat.phase      = phase_ff;
   assign stat.close      = close_ff;
   assign stat.depth_zero = depth_ff == '0;
   assign stat.scat_zero  = scat_ff == '0;
   assign stat.mom0_zero  = msum_ff[0] == '0;
   assign stat.div_done   = div_done;
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

endmodule

`default_nettype wire

/* hdl/lopm_ctrl.sv */
// Controller: sequences multiply-accumulate per request and the divisions per layer.
// Depends on lopm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lopm_ctrl #(
   parameter int MOMENT_TERMS = lopm_pkg::MOMENT_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  lopm_pkg::lopm_stat_type stat,
   output lopm_pkg::lopm_cmd_type  cmd
);

   localparam int NUM_ACC = (MOMENT_TERMS < lopm_pkg::INPUT_MOMENTS) ?
                            MOMENT_TERMS : lopm_pkg::INPUT_MOMENTS;
   localparam int TW = lopm_pkg::TERM_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SC    = 3'd1;
   localparam logic [2:0] S_TERM  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_START = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_PUB   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [TW-1:0] term_ff, term_in;
   logic [TW-1:0] job_ff, job_in;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.term = term_ff;
      cmd.job  = job_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.item_in) begin
               state_in = S_SC;
            end
         end
         S_SC: begin
            cmd.mul_sc = 1'b1;
            term_in    = '0;
            state_in   = S_TERM;
         end
         S_TERM: begin
            cmd.mul_term = 1'b1;
            if ((term_ff == '0 && !stat.phase) || term_ff == TW'(NUM_ACC)) begin
               state_in = S_DRAIN;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = stat.close ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            cmd.div_phase = 1'b1;
            cmd.clear_res = 1'b1;
            job_in        = lopm_pkg::JOB_ALBEDO;
            state_in      = stat.depth_zero ? S_PUB : S_START;
         end
         S_START: begin
            cmd.div_phase = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_phase = 1'b1;
            if (stat.div_done) begin
               cmd.store = 1'b1;
               state_in  = S_START;
               job_in    = job_ff + 1'b1;
               if (job_ff == lopm_pkg::JOB_ALBEDO) begin
                  if (stat.scat_zero) begin
                     state_in = S_PUB;
                  end
               end else if (job_ff == lopm_pkg::JOB_ASYM) begin
                  if (stat.mom0_zero || NUM_ACC == 1) begin
                     state_in = S_PUB;
                  end
               end else if (job_ff == TW'(NUM_ACC)) begin
                  state_in = S_PUB;
               end
            end
         end
         S_PUB: begin
            cmd.div_phase = 1'b1;
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff  <= '0;
         job_ff   <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         job_ff   <= job_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/lopm_checker.sv */
// Port-level checks for layer_optical_property_mixer, attached by bind.
// Depends on lopm_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module lopm_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [39:0] tau_total,
   input wire logic [15:0] layer_albedo,
   input wire logic [15:0] layer_asymmetry,
   input wire logic [15:0] norm_moment_two,
   input wire logic [15:0] norm_moment_three,
   input wire logic [15:0] norm_moment_four,
   input wire logic [15:0] norm_moment_five,
   input wire logic [1:0]  status
);

   logic moms_zero;
   assign moms_zero = norm_moment_two == '0 && norm_moment_three == '0 &&
                      norm_moment_four == '0 && norm_moment_five == '0;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(tau_total))
      else $error("response changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == lopm_pkg::ST_ZERO_DEPTH |->
         tau_total == '0 && layer_albedo == '0 && layer_asymmetry == '0 && moms_zero)
      else $error("zero depth response carries data");

   a_albedo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> layer_albedo <= lopm_pkg::ALBEDO_ONE)
      else $error("albedo above one");

   a_moments: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != lopm_pkg::ST_OK |-> moms_zero)
      else $error("moments nonzero with error status");

endmodule

bind layer_optical_property_mixer lopm_port_checker u_lopm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .tau_total         (rsp_bus.tau_total),
   .layer_albedo      (rsp_bus.layer_albedo),
   .layer_asymmetry   (rsp_bus.layer_asymmetry),
   .norm_moment_two   (rsp_bus.norm_moment_two),
   .norm_moment_three (rsp_bus.norm_moment_three),
   .norm_moment_four  (rsp_bus.norm_moment_four),
   .norm_moment_five  (rsp_bus.norm_moment_five),
   .status            (rsp_bus.status)
);

`default_nettype wire
